FILE: rtl/core/chained_bucket_hash_map_macros.svh
// ----------------------------------------------------------------------------
// Chained bucket hash map assertion macros
// Clocked assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef CHAINED_BUCKET_HASH_MAP_MACROS_SVH
`define CHAINED_BUCKET_HASH_MAP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define CBHM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define CBHM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CBHM_ASSERT_NOW(lbl, ante, cons)
`define CBHM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/cbhm_pkg.sv
// ----------------------------------------------------------------------------
// Chained bucket hash map package
// Sizes, codes and transfer structs shared by the map's modules.
// ----------------------------------------------------------------------------
package cbhm_pkg;

    localparam int unsigned BUCKETS        = 256;
    localparam int unsigned SLOTS_PER_NODE = 4;
    localparam int unsigned NODE_POOL      = 1024;
    localparam int unsigned TOTAL_SLOTS    = NODE_POOL * SLOTS_PER_NODE;

    localparam int unsigned BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned NODE_W  = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
    localparam int unsigned USED_W  = $clog2(NODE_POOL + 1);
    localparam int unsigned SLOT_W  = (SLOTS_PER_NODE > 1) ? $clog2(SLOTS_PER_NODE) : 1;
    localparam int unsigned ADDR_W  = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam int unsigned LINK_W  = NODE_W + 1;
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VAL_W   = 64;
    localparam int unsigned COUNT_W = 13;

    localparam logic [KEY_W-1:0] EMPTY_KEY = 32'hFFFF_FFFF;

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_SET   = 2'd0;
    localparam t_opcode OP_GET   = 2'd1;
    localparam t_opcode OP_CLEAR = 2'd2;
    localparam t_opcode OP_NOP   = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_BAD_KEY = 2'd1;
    localparam t_status ST_NO_NODE = 2'd2;

    typedef struct packed {
        t_opcode     opcode;
        logic [31:0] page_key;
        logic [31:0] new_phys_page;
        logic [31:0] new_version;
    } t_cmd;

    typedef struct packed {
        t_status             status;
        logic                hit;
        logic [31:0]         found_phys_page;
        logic [31:0]         found_version;
        logic [COUNT_W-1:0]  entry_count;
    } t_result;

    typedef struct packed {
        logic is_empty;
        logic is_match;
    } t_cmp;

endpackage

FILE: rtl/core/cbhm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cbhm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/cbhm_cmp.sv
// ----------------------------------------------------------------------------
// Slot key compare unit
// Flag a stored slot key as empty or as equal to the search key.
// ----------------------------------------------------------------------------
module cbhm_cmp (
    input  logic [cbhm_pkg::KEY_W-1:0] i_slot_key,
    input  logic [cbhm_pkg::KEY_W-1:0] i_search_key,
    output cbhm_pkg::t_cmp             o_cmp
);

    always_comb begin
        o_cmp.is_empty = (i_slot_key == cbhm_pkg::EMPTY_KEY);
        o_cmp.is_match = (i_slot_key == i_search_key);
    end

endmodule

FILE: rtl/core/chained_bucket_hash_map.sv
// ----------------------------------------------------------------------------
// Chained bucket hash map
// Page id to (physical page, version) map; buckets chain fixed-size nodes
// taken in order from a shared pool, walked slot by slot by one sequencer.
// ----------------------------------------------------------------------------
//  channel   ports                        transfer
//  command   start, busy, i_cmd           edge with start high and busy low
//  result    o_valid, o_result            one-cycle strobe, always taken
//
//  Clear, an invalid key, an unknown opcode, a get on an empty bucket or a full
//  pool there answer from dispatch. A walk reads the head, each slot key in turn
//  and the link after a node's last slot; then a get hit reads the value or a set
//  writes it. A set that takes a new node empties its slots before its write.
//  Reset: synchronous; clears bucket valid bits and counters.
//  The receiver cannot stall; busy stays high from transfer to result.
// ----------------------------------------------------------------------------
`include "chained_bucket_hash_map_macros.svh"

module chained_bucket_hash_map (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  cbhm_pkg::t_cmd    i_cmd,
    output logic              busy,
    output logic              o_valid,
    output cbhm_pkg::t_result o_result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_HEAD,
        S_KEY_RD,
        S_KEY_CMP,
        S_LINK,
        S_INIT,
        S_WRITE,
        S_VAL
    } t_state;

    t_state r_state, n_state;

    // Latched command
    cbhm_pkg::t_cmd r_cmd, n_cmd;

    // Walk position
    logic [cbhm_pkg::NODE_W-1:0] r_node, n_node;
    logic [cbhm_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic                        r_found, n_found;

    // Table bookkeeping
    logic [cbhm_pkg::BUCKETS-1:0] r_head_vld, n_head_vld;
    logic [cbhm_pkg::USED_W-1:0]  r_used, n_used;
    logic [cbhm_pkg::COUNT_W-1:0] r_stored, n_stored;

    // Registered result
    logic              r_valid, n_valid;
    cbhm_pkg::t_result r_result, n_result;

    // Memory ports
    logic                          head_we, head_re;
    logic [cbhm_pkg::NODE_W-1:0]   head_rdata;
    logic                          link_we, link_re;
    logic [cbhm_pkg::LINK_W-1:0]   link_wdata, link_rdata;
    logic [cbhm_pkg::NODE_W-1:0]   link_waddr;
    logic                          key_we, key_re;
    logic [cbhm_pkg::KEY_W-1:0]    key_wdata, key_rdata;
    logic                          val_we, val_re;
    logic [cbhm_pkg::VAL_W-1:0]    val_rdata;
    logic [cbhm_pkg::ADDR_W-1:0]   slot_addr;

    logic [cbhm_pkg::BKT_W-1:0]    bucket;
    logic                          pool_full;
    logic                          last_slot;
    cbhm_pkg::t_cmp                cmp;

    // Bucket is the key modulo the bucket count.
    assign bucket    = cbhm_pkg::BKT_W'(r_cmd.page_key % cbhm_pkg::BUCKETS);
    assign pool_full = (r_used == cbhm_pkg::USED_W'(cbhm_pkg::NODE_POOL));
    assign last_slot = (r_slot == cbhm_pkg::SLOT_W'(cbhm_pkg::SLOTS_PER_NODE - 1));
    assign slot_addr = cbhm_pkg::ADDR_W'(r_node) * cbhm_pkg::ADDR_W'(cbhm_pkg::SLOTS_PER_NODE)
                     + cbhm_pkg::ADDR_W'(r_slot);

    cbhm_cmp u_cmp (
        .i_slot_key   (key_rdata),
        .i_search_key (r_cmd.page_key),
        .o_cmp        (cmp)
    );

    cbhm_ram #(.WIDTH(cbhm_pkg::NODE_W), .DEPTH(cbhm_pkg::BUCKETS)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (bucket),
        .i_wdata (r_used[cbhm_pkg::NODE_W-1:0]),
        .i_re    (head_re),
        .i_raddr (bucket),
        .o_rdata (head_rdata)
    );

    cbhm_ram #(.WIDTH(cbhm_pkg::LINK_W), .DEPTH(cbhm_pkg::NODE_POOL)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (r_node),
        .o_rdata (link_rdata)
    );

    cbhm_ram #(.WIDTH(cbhm_pkg::KEY_W), .DEPTH(cbhm_pkg::TOTAL_SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (slot_addr),
        .i_wdata (key_wdata),
        .i_re    (key_re),
        .i_raddr (slot_addr),
        .o_rdata (key_rdata)
    );

    cbhm_ram #(.WIDTH(cbhm_pkg::VAL_W), .DEPTH(cbhm_pkg::TOTAL_SLOTS)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (slot_addr),
        .i_wdata ({r_cmd.new_version, r_cmd.new_phys_page}),
        .i_re    (val_re),
        .i_raddr (slot_addr),
        .o_rdata (val_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_node     = r_node;
        n_slot     = r_slot;
        n_found    = r_found;
        n_head_vld = r_head_vld;
        n_used     = r_used;
        n_stored   = r_stored;
        n_valid    = 1'b0;
        n_result   = r_result;

        head_we    = 1'b0;
        head_re    = 1'b0;
        link_we    = 1'b0;
        link_re    = 1'b0;
        link_waddr = r_node;
        link_wdata = '0;
        key_we     = 1'b0;
        key_re     = 1'b0;
        key_wdata  = cbhm_pkg::EMPTY_KEY;
        val_we     = 1'b0;
        val_re     = 1'b0;

        // Default result: ok, miss, zero descriptor, current count.
        n_result.status          = cbhm_pkg::ST_OK;
        n_result.hit             = 1'b0;
        n_result.found_phys_page = '0;
        n_result.found_version   = '0;
        n_result.entry_count     = r_stored;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                n_slot  = '0;
                n_found = 1'b0;
                if (r_cmd.opcode == cbhm_pkg::OP_CLEAR) begin
                    // Drop every chain; nodes are re-initialized when taken again.
                    n_head_vld           = '0;
                    n_used               = '0;
                    n_stored             = '0;
                    n_result.entry_count = '0;
                    n_valid              = 1'b1;
                    n_state              = S_IDLE;
                end else if (r_cmd.opcode != cbhm_pkg::OP_SET
                             && r_cmd.opcode != cbhm_pkg::OP_GET) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (r_cmd.page_key == cbhm_pkg::EMPTY_KEY) begin
                    n_result.status = cbhm_pkg::ST_BAD_KEY;
                    n_valid         = 1'b1;
                    n_state         = S_IDLE;
                end else if (r_head_vld[bucket]) begin
                    head_re = 1'b1;
                    n_state = S_HEAD;
                end else if (r_cmd.opcode == cbhm_pkg::OP_GET) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (pool_full) begin
                    n_result.status = cbhm_pkg::ST_NO_NODE;
                    n_valid         = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    // Take a node as the bucket's first.
                    head_we            = 1'b1;
                    n_head_vld[bucket] = 1'b1;
                    n_node             = r_used[cbhm_pkg::NODE_W-1:0];
                    n_used             = r_used + cbhm_pkg::USED_W'(1);
                    n_state            = S_INIT;
                end
            end

            S_HEAD: begin
                n_node  = head_rdata;
                n_state = S_KEY_RD;
            end

            S_KEY_RD: begin
                key_re  = 1'b1;
                n_state = S_KEY_CMP;
            end

            S_KEY_CMP: begin
                if (cmp.is_empty) begin
                    if (r_cmd.opcode == cbhm_pkg::OP_GET) begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_WRITE;
                    end
                end else if (cmp.is_match) begin
                    n_found = 1'b1;
                    if (r_cmd.opcode == cbhm_pkg::OP_GET) begin
                        val_re  = 1'b1;
                        n_state = S_VAL;
                    end else begin
                        n_state = S_WRITE;
                    end
                end else if (last_slot) begin
                    link_re = 1'b1;
                    n_state = S_LINK;
                end else begin
                    n_slot  = r_slot + cbhm_pkg::SLOT_W'(1);
                    n_state = S_KEY_RD;
                end
            end

            S_LINK: begin
                n_slot = '0;
                if (link_rdata[cbhm_pkg::NODE_W]) begin
                    n_node  = link_rdata[cbhm_pkg::NODE_W-1:0];
                    n_state = S_KEY_RD;
                end else if (r_cmd.opcode == cbhm_pkg::OP_GET) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (pool_full) begin
                    n_result.status = cbhm_pkg::ST_NO_NODE;
                    n_valid         = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    // Tail is full: hang a fresh node off it.
                    link_we    = 1'b1;
                    link_wdata = {1'b1, r_used[cbhm_pkg::NODE_W-1:0]};
                    n_node     = r_used[cbhm_pkg::NODE_W-1:0];
                    n_used     = r_used + cbhm_pkg::USED_W'(1);
                    n_state    = S_INIT;
                end
            end

            S_INIT: begin
                // Empty one slot a cycle; clear the node's link on the first.
                key_we = 1'b1;
                if (r_slot == '0) begin
                    link_we = 1'b1;
                end
                if (last_slot) begin
                    n_slot  = '0;
                    n_state = S_WRITE;
                end else begin
                    n_slot = r_slot + cbhm_pkg::SLOT_W'(1);
                end
            end

            S_WRITE: begin
                key_we    = 1'b1;
                key_wdata = r_cmd.page_key;
                val_we    = 1'b1;
                if (!r_found) begin
                    n_stored = r_stored + cbhm_pkg::COUNT_W'(1);
                end
                n_result.entry_count = n_stored;
                n_valid              = 1'b1;
                n_state              = S_IDLE;
            end

            S_VAL: begin
                n_result.hit             = 1'b1;
                n_result.found_phys_page = val_rdata[31:0];
                n_result.found_version   = val_rdata[63:32];
                n_valid                  = 1'b1;
                n_state                  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head_vld <= '0;
            r_used     <= '0;
            r_stored   <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head_vld <= n_head_vld;
            r_used     <= n_used;
            r_stored   <= n_stored;
            r_valid    <= n_valid;
        end
        r_cmd    <= n_cmd;
        r_node   <= n_node;
        r_slot   <= n_slot;
        r_found  <= n_found;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    `CBHM_ASSERT_NEXT(a_strobe_single, r_valid, !r_valid)
    `CBHM_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
    `CBHM_ASSERT_NOW(a_pool_bound, 1'b1, r_used <= cbhm_pkg::USED_W'(cbhm_pkg::NODE_POOL))
    `CBHM_ASSERT_NOW(a_count_match, r_valid, r_result.entry_count == r_stored)

endmodule
